@@ hw/rtl/lftl_pkg.sv @@
`default_nettype none
package lftl_pkg;

   localparam int MAX_FRAMES_DEF = 1024;
   localparam int STAMP_W = 48;
   localparam int HINT_W = 40;
   localparam int INDEX_W = 10;
   localparam int WIDE_W = 64;
   localparam logic [HINT_W-1:0] FALLBACK_RESET = 40'd100;

   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_LOOKUP  = 2'd1,
      FUNC_RESTART = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [STAMP_W-1:0] stamp_ticks;
      logic [HINT_W-1:0]         duration_hint;
      logic signed [STAMP_W-1:0] query_time;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [INDEX_W-1:0] frame_index;
      logic               changed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEARCH,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_cmd_type;

endpackage
`default_nettype wire

@@ hw/rtl/looping_frame_time_lookup.sv @@
`default_nettype none
// Load and restart requests are handled in the idle state. Lookup: busy through the
// 64-step remainder unit, with its start and done, and the search, each step of which
// passes the SEARCH, READ and CMP states (the memory probe); result in the cycle after.
// Zero loop length skips the remainder unit; no frames loaded: result next cycle.
// One request at a time, busy high meanwhile. Result strobe lasts one cycle.
// Synchronous active-high reset clears control state; frame store is not cleared.
module looping_frame_time_lookup
   import lftl_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [HINT_W-1:0] csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_FRAMES);
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

   state_type state_ff, state_in;
   logic [HINT_W-1:0]  fallback_ff, fallback_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STAMP_W-1:0] first_ff, first_in;
   logic [STAMP_W-1:0] prev_ff, prev_in;
   logic               rising_ff, rising_in;
   logic [HINT_W-1:0]  good_ff, good_in;
   logic [ADDR_W-1:0]  shown_ff, shown_in;
   logic               shown_valid_ff, shown_valid_in;
   logic [63:0]        into_ff, into_in;
   logic [63:0]        step_ff, step_in;
   logic [CNT_W-1:0]   low_ff, low_in, high_ff, high_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   div_cmd_type        div_cmd;
   logic               div_done;
   logic [63:0]        div_rem;
   logic               wr_en;
   logic [STAMP_W-1:0] rel;
   logic [STAMP_W-1:0] stamp_first;
   logic [STAMP_W-1:0] rd_data;
   logic [63:0]        step_w;
   logic [63:0]        loop_w;
   logic [63:0]        uni_start;
   logic [63:0]        cand;
   logic [CNT_W:0]     mid_sum;

   lftl_store #(.MAX_FRAMES(MAX_FRAMES), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (rel),
      .rd_addr (mid_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   lftl_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .rem   (div_rem)
   );

   assign stamp_first = (count_ff == '0) ? req_data.stamp_ticks : first_ff;
   assign rel = req_data.stamp_ticks - stamp_first;
   assign wr_en = (state_ff == ST_IDLE) && start && (req_data.func == FUNC_LOAD)
                  && (count_ff != CNT_W'(MAX_FRAMES));
   assign step_w = (good_ff != '0) ? {24'd0, good_ff} : {24'd0, fallback_ff};
   assign uni_start = step_ff * {{(64-CNT_W){1'b0}}, mid_ff};
   assign cand = rising_ff ? {{16{rd_data[STAMP_W-1]}}, rd_data} : uni_start;
   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff} + {{CNT_W{1'b0}}, 1'b1};

   always_comb begin
      if (rising_ff) begin
         loop_w = {{16{prev_ff[STAMP_W-1]}}, prev_ff} + step_w;
      end else begin
         loop_w = step_w * {{(64-CNT_W){1'b0}}, count_ff};
      end
      if (loop_w[63] || loop_w == 64'd0) begin
         loop_w = {24'd0, fallback_ff};
      end
   end

   always_comb begin
      state_in       = state_ff;
      fallback_in    = csr_wr_en ? csr_wr_data : fallback_ff;
      count_in       = count_ff;
      first_in       = first_ff;
      prev_in        = prev_ff;
      rising_in      = rising_ff;
      good_in        = good_ff;
      shown_in       = shown_ff;
      shown_valid_in = shown_valid_ff;
      into_in        = into_ff;
      step_in        = step_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      mid_in         = mid_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      div_cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.func)
                  FUNC_LOAD: begin
                     if (wr_en) begin
                        first_in = stamp_first;
                        if (count_ff != '0 && $signed(rel) <= $signed(prev_ff)) begin
                           rising_in = 1'b0;
                        end
                        prev_in = rel;
                        if (req_data.duration_hint != '0) begin
                           good_in = req_data.duration_hint;
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_LOOKUP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: 1'b1, frame_index: '0, changed: 1'b0};
                     end else begin
                        step_in = step_w;
                        low_in  = '0;
                        high_in = count_ff - CNT_W'(1);
                        if (loop_w == 64'd0) begin
                           into_in  = '0;
                           state_in = ST_SEARCH;
                        end else begin
                           div_cmd.start    = 1'b1;
                           div_cmd.dividend = {{16{req_data.query_time[STAMP_W-1]}},
                                               req_data.query_time};
                           div_cmd.divisor  = loop_w;
                           state_in = ST_DIV;
                        end
                     end
                  end
                  FUNC_RESTART: begin
                     count_in       = '0;
                     first_in       = '0;
                     prev_in        = '0;
                     rising_in      = 1'b1;
                     good_in        = '0;
                     shown_in       = '0;
                     shown_valid_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               into_in  = div_rem;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (low_ff < high_ff) begin
               mid_in   = mid_sum[CNT_W:1];
               state_in = ST_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ($signed(cand) <= $signed(into_ff)) begin
               low_in = mid_ff;
            end else begin
               high_in = mid_ff - CNT_W'(1);
            end
            state_in = ST_SEARCH;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = 1'b0;
            rsp_in.frame_index = INDEX_W'(low_ff);
            rsp_in.changed = !shown_valid_ff || (shown_ff != low_ff[ADDR_W-1:0]);
            shown_in = low_ff[ADDR_W-1:0];
            shown_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fallback_ff    <= FALLBACK_RESET;
         count_ff       <= '0;
         first_ff       <= '0;
         prev_ff        <= '0;
         rising_ff      <= 1'b1;
         good_ff        <= '0;
         shown_ff       <= '0;
         shown_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fallback_ff    <= fallback_in;
         count_ff       <= count_in;
         first_ff       <= first_in;
         prev_ff        <= prev_in;
         rising_ff      <= rising_in;
         good_ff        <= good_in;
         shown_ff       <= shown_in;
         shown_valid_ff <= shown_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      into_ff <= into_in;
      step_ff <= step_in;
      low_ff  <= low_in;
      high_ff <= high_in;
      mid_ff  <= mid_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAMES)) else $error("frame count overflow");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (mid_ff > low_ff && mid_ff <= high_ff))
      else $error("search probe out of bounds");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (rsp_valid && !rsp_data.status))
      else $error("missing lookup result");

endmodule
`default_nettype wire

@@ hw/rtl/lftl_divider.sv @@
`default_nettype none
// Restoring divider: signed dividend, positive divisor, non-negative remainder out.
module lftl_divider
   import lftl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_cmd_type cmd,
   output logic             done,
   output logic [63:0]      rem
);

   logic [63:0] quo_ff, quo_in;
   logic [64:0] acc_ff, acc_in;
   logic [63:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic [64:0] diff;
   logic [63:0] fix;

   always_comb begin
      quo_in  = quo_ff;
      acc_in  = acc_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {acc_ff[63:0], quo_ff[63]};
      diff    = shifted - {1'b0, dvs_ff};
      if (cmd.start) begin
         neg_in = cmd.dividend[63];
         quo_in = cmd.dividend[63] ? (64'd0 - cmd.dividend) : cmd.dividend;
         acc_in = '0;
         dvs_in = cmd.divisor;
         cnt_in = 7'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         acc_in = diff[64] ? shifted : diff;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      acc_ff <= acc_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign fix  = (neg_ff && acc_ff[63:0] != 64'd0) ? (dvs_ff - acc_ff[63:0]) : acc_ff[63:0];
   assign done = done_ff;
   assign rem  = fix;

endmodule
`default_nettype wire

@@ hw/rtl/lftl_store.sv @@
`default_nettype none
module lftl_store
   import lftl_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int ADDR_W = $clog2(MAX_FRAMES)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire logic [STAMP_W-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output logic [STAMP_W-1:0]       rd_data
);

   logic [STAMP_W-1:0] mem [MAX_FRAMES];
   logic [STAMP_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire
